[sv/d2vn_pkg.sv]
// shared types and constants of the depth to vertex and normal map block
// used by every module of the block but the ram, depends on nothing

package d2vn_pkg;

  localparam int MAX_WIDTH   = 1024;
  localparam int COL_W       = $clog2(MAX_WIDTH);
  localparam int ADDR_W      = COL_W + 1;
  localparam int STORE_DEPTH = 2 * MAX_WIDTH;
  localparam int ROW_W       = 12;
  localparam int WID_W       = 11;
  localparam int DEPTH_W     = 16;
  localparam int VERT_W      = 24;
  localparam int NORM_W      = 16;
  localparam int MEM_W       = 2 * VERT_W + DEPTH_W;
  localparam int DIV_NUM_W   = 48;
  localparam int DIV_DEN_W   = 34;
  localparam int NACC_W      = 52;
  localparam int MAG_W       = NACC_W - 1;
  localparam int LEN_W       = 33;
  localparam int FIFO_DEPTH  = 2;
  localparam int SQRT_STEPS  = 32;

  localparam logic [DIV_NUM_W-1:0] VERT_POS_LIM = DIV_NUM_W'(8388607);
  localparam logic [DIV_NUM_W-1:0] VERT_NEG_LIM = DIV_NUM_W'(8388608);
  localparam logic [DIV_NUM_W-1:0] UNIT_Q       = DIV_NUM_W'(16384);

  typedef enum logic [2:0] {
    REG_WIDTH  = 3'd0,
    REG_HEIGHT = 3'd1,
    REG_LIMIT  = 3'd2,
    REG_FX     = 3'd3,
    REG_FY     = 3'd4,
    REG_CX     = 3'd5,
    REG_CY     = 3'd6
  } reg_idx_t;

  typedef struct packed {
    logic [WID_W-1:0]   row_pixels;
    logic [ROW_W-1:0]   frame_rows;
    logic [DEPTH_W-1:0] depth_limit;
    logic [15:0]        focal_len_x;
    logic [15:0]        focal_len_y;
    logic [15:0]        center_x;
    logic [15:0]        center_y;
  } cfg_t;

  // one classified pixel handed from the front to the back
  typedef struct packed {
    logic [DEPTH_W-1:0] z;
    logic [15:0]        dx_mag;
    logic               dx_neg;
    logic [15:0]        dy_mag;
    logic               dy_neg;
    logic               nvalid;
    logic               full;
    logic [ADDR_W-1:0]  cur;
    logic [ADDR_W-1:0]  left;
    logic [ADDR_W-1:0]  right;
  } item_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_BP_MUL,
    ST_BP_DIV,
    ST_BP_WAIT,
    ST_RD,
    ST_CROSS,
    ST_ABS,
    ST_SHIFT,
    ST_SQ,
    ST_SQRT,
    ST_ND_GO,
    ST_ND_WAIT,
    ST_DONE
  } bstate_t;

endpackage

[sv/d2vn_ram.sv]
// generic single write port, single read port ram with registered read
// no dependencies

module d2vn_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[sv/d2vn_div.sv]
// bit-serial restoring divider, one quotient bit per cycle
// depends on d2vn_pkg

module d2vn_div (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  input  logic [d2vn_pkg::DIV_NUM_W-1:0]   num,
  input  logic [d2vn_pkg::DIV_DEN_W-1:0]   den,
  output logic                             busy,
  output logic                             done,
  output logic [d2vn_pkg::DIV_NUM_W-1:0]   quo
);
  import d2vn_pkg::*;

  localparam int CNT_W = $clog2(DIV_NUM_W);

  logic [DIV_DEN_W-1:0] rem;
  logic [DIV_DEN_W-1:0] dsr;
  logic [CNT_W-1:0]     cnt;
  logic [DIV_DEN_W:0]   trial;
  logic                 fits;

  assign trial = {rem, quo[DIV_NUM_W-1]};
  assign fits  = trial >= {1'b0, dsr};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == CNT_W'(DIV_NUM_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      dsr <= den;
      quo <= num;
    end else if (busy) begin
      rem <= fits ? DIV_DEN_W'(trial - {1'b0, dsr}) : trial[DIV_DEN_W-1:0];
      quo <= {quo[DIV_NUM_W-2:0], fits};
    end
  end

endmodule

[sv/d2vn_fifo.sv]
// short queue of classified pixels between the front and the back
// depends on d2vn_pkg

module d2vn_fifo (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push,
  input  d2vn_pkg::item_t       push_item,
  input  logic                  pop,
  output d2vn_pkg::item_t       pop_item,
  output logic                  full,
  output logic                  empty
);
  import d2vn_pkg::*;

  localparam int PTR_W = $clog2(FIFO_DEPTH);

  item_t             slots [FIFO_DEPTH];
  logic [PTR_W-1:0]  wr_ptr;
  logic [PTR_W-1:0]  rd_ptr;
  logic [PTR_W:0]    count;

  assign full     = count == (PTR_W + 1)'(FIFO_DEPTH);
  assign empty    = count == '0;
  assign pop_item = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(FIFO_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(FIFO_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_item;
    end
  end

endmodule

[sv/d2vn_front.sv]
// input side: raster position counters, depth cut, offsets and store addresses
// depends on d2vn_pkg

module d2vn_front (
  input  logic                        clk,
  input  logic                        rst,
  input  d2vn_pkg::cfg_t              cfg,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [d2vn_pkg::DEPTH_W-1:0] depth_mm,
  input  logic                        frame_start,
  input  logic                        q_full,
  output logic                        q_push,
  output d2vn_pkg::item_t             q_item
);
  import d2vn_pkg::*;

  logic [COL_W-1:0] col_cnt;
  logic [ROW_W-1:0] row_cnt;
  logic [COL_W-1:0] col_cnt_next;
  logic [ROW_W-1:0] row_cnt_next;
  logic [COL_W:0]   wc;
  logic [ROW_W-1:0] hc;
  logic [COL_W-1:0] col0;
  logic [ROW_W-1:0] row0;
  logic [ROW_W:0]   row1;
  logic [COL_W-1:0] c;
  logic [ROW_W-1:0] r;
  logic [COL_W:0]   c_inc;
  logic [ROW_W:0]   r_inc;
  logic signed [17:0] dx;
  logic signed [17:0] dy;
  logic signed [17:0] dx_abs;
  logic signed [17:0] dy_abs;

  assign in_ready = !q_full;
  assign q_push   = in_valid && !q_full;

  always_comb begin
    if (cfg.row_pixels < WID_W'(3)) begin
      wc = (COL_W + 1)'(3);
    end else if (32'(cfg.row_pixels) > MAX_WIDTH) begin
      wc = (COL_W + 1)'(MAX_WIDTH);
    end else begin
      wc = (COL_W + 1)'(cfg.row_pixels);
    end
    hc = (cfg.frame_rows < ROW_W'(3)) ? ROW_W'(3) : cfg.frame_rows;

    col0 = frame_start ? '0 : col_cnt;
    row0 = frame_start ? '0 : row_cnt;
    // a column at or past the width starts the next row
    if ({1'b0, col0} >= wc) begin
      c    = '0;
      row1 = {1'b0, row0} + 1'b1;
    end else begin
      c    = col0;
      row1 = {1'b0, row0};
    end
    r = (row1 >= {1'b0, hc}) ? '0 : row1[ROW_W-1:0];

    c_inc = {1'b0, c} + 1'b1;
    r_inc = {1'b0, r} + 1'b1;
    if (c_inc >= wc) begin
      col_cnt_next = '0;
      row_cnt_next = (r_inc >= {1'b0, hc}) ? '0 : r_inc[ROW_W-1:0];
    end else begin
      col_cnt_next = c_inc[COL_W-1:0];
      row_cnt_next = r;
    end
  end

  always_comb begin
    dx     = $signed(18'({c, 4'b0000})) - $signed({2'b00, cfg.center_x});
    dy     = $signed(18'({r, 4'b0000})) - $signed({2'b00, cfg.center_y});
    dx_abs = dx[17] ? -dx : dx;
    dy_abs = dy[17] ? -dy : dy;

    q_item.z      = (depth_mm > cfg.depth_limit) ? '0 : depth_mm;
    q_item.dx_mag = dx_abs[15:0];
    q_item.dx_neg = dx[17];
    q_item.dy_mag = dy_abs[15:0];
    q_item.dy_neg = dy[17];
    q_item.nvalid = r != '0;
    // interior pixel above: needs two rows behind it and both side neighbors
    q_item.full   = (r >= ROW_W'(2)) && (c != '0) && ({1'b0, c} != wc - 1'b1);
    q_item.cur    = {r[0], c};
    q_item.left   = {~r[0], c - 1'b1};
    q_item.right  = {~r[0], c + 1'b1};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col_cnt <= '0;
      row_cnt <= '0;
    end else if (q_push) begin
      col_cnt <= col_cnt_next;
      row_cnt <= row_cnt_next;
    end
  end

endmodule

[sv/d2vn_back.sv]
// back side: back-projection, line store, cross product, length and unit scaling
// depends on d2vn_pkg, d2vn_ram, d2vn_div

module d2vn_back (
  input  logic                              clk,
  input  logic                              rst,
  input  d2vn_pkg::cfg_t                    cfg,
  input  logic                              q_empty,
  input  d2vn_pkg::item_t                   q_item,
  output logic                              q_pop,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic signed [d2vn_pkg::VERT_W-1:0] vert_x,
  output logic signed [d2vn_pkg::VERT_W-1:0] vert_y,
  output logic [d2vn_pkg::DEPTH_W-1:0]      vert_z,
  output logic                              normal_valid,
  output logic signed [d2vn_pkg::NORM_W-1:0] norm_x,
  output logic signed [d2vn_pkg::NORM_W-1:0] norm_y,
  output logic signed [d2vn_pkg::NORM_W-1:0] norm_z
);
  import d2vn_pkg::*;

  bstate_t state;
  bstate_t state_next;

  item_t                    itm;
  logic                     axis;
  logic [5:0]               step;
  logic [1:0]               k;
  logic signed [VERT_W-1:0] vx;
  logic signed [VERT_W-1:0] vy;
  logic signed [VERT_W:0]   ax, ay, bx, by;
  logic signed [DEPTH_W:0]  az, bz;
  logic signed [63:0]       prod;
  logic signed [31:0]       mul_a;
  logic signed [31:0]       mul_b;
  logic signed [63:0]       mul_p;
  logic signed [NACC_W-1:0] n    [3];
  logic [MAG_W-1:0]         mag  [3];
  logic                     nneg [3];
  logic signed [NORM_W-1:0] nrm  [3];
  logic [63:0]              sum;
  logic [63:0]              sq_v;
  logic [63:0]              sq_r;
  logic [63:0]              sq_bit;
  logic [63:0]              sq_try;
  logic [LEN_W-1:0]         len;
  logic                     any_big;
  logic                     all_zero;
  logic                     slot_free;

  logic                     div_start;
  logic [DIV_NUM_W-1:0]     div_num;
  logic [DIV_DEN_W-1:0]     div_den;
  logic                     div_busy;
  logic                     div_done;
  logic [DIV_NUM_W-1:0]     div_quo;
  logic [15:0]              ff;
  logic [VERT_W-1:0]        bp_val;
  logic [NORM_W-1:0]        nd_val;

  logic                     ram_we;
  logic [ADDR_W-1:0]        ram_raddr;
  logic [MEM_W-1:0]         ram_rdata;
  logic signed [VERT_W-1:0] rd_x;
  logic signed [VERT_W-1:0] rd_y;
  logic [DEPTH_W-1:0]       rd_z;
  logic                     load_out;

  d2vn_ram #(
    .WIDTH(MEM_W),
    .DEPTH(STORE_DEPTH)
  ) u_store (
    .clk  (clk),
    .we   (ram_we),
    .waddr(itm.cur),
    .wdata({vx, vy, itm.z}),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  d2vn_div u_div (
    .clk  (clk),
    .rst  (rst),
    .start(div_start),
    .num  (div_num),
    .den  (div_den),
    .busy (div_busy),
    .done (div_done),
    .quo  (div_quo)
  );

  assign rd_x      = ram_rdata[MEM_W-1 -: VERT_W];
  assign rd_y      = ram_rdata[DEPTH_W +: VERT_W];
  assign rd_z      = ram_rdata[DEPTH_W-1:0];
  assign len       = sq_r[LEN_W-1:0];
  assign slot_free = !out_valid || out_ready;
  assign any_big   = (mag[0][MAG_W-1:31] != '0) || (mag[1][MAG_W-1:31] != '0)
                  || (mag[2][MAG_W-1:31] != '0);
  assign all_zero  = (n[0] == '0) && (n[1] == '0) && (n[2] == '0);
  assign sq_try    = sq_r + sq_bit;
  assign mul_p     = mul_a * mul_b;

  always_comb begin
    ff = axis ? cfg.focal_len_y : cfg.focal_len_x;
    if (ff == '0) begin
      ff = 16'd1;
    end
  end

  // saturated back-projection result, halves already rounded away from zero; signed normal component
  always_comb begin
    if (axis ? itm.dy_neg : itm.dx_neg) begin
      bp_val = (div_quo > VERT_NEG_LIM) ? VERT_W'(VERT_NEG_LIM)
                                        : VERT_W'(-div_quo[VERT_W-1:0]);
    end else begin
      bp_val = (div_quo > VERT_POS_LIM) ? VERT_W'(VERT_POS_LIM) : div_quo[VERT_W-1:0];
    end
    nd_val = nneg[k] ? NORM_W'(-div_quo[NORM_W-1:0]) : div_quo[NORM_W-1:0];
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:    if (!q_empty) state_next = ST_BP_MUL;
      ST_BP_MUL:  state_next = ST_BP_DIV;
      ST_BP_DIV:  state_next = ST_BP_WAIT;
      ST_BP_WAIT: begin
        if (div_done) begin
          if (!axis) begin
            state_next = ST_BP_MUL;
          end else if (itm.full) begin
            state_next = ST_RD;
          end else begin
            state_next = ST_DONE;
          end
        end
      end
      ST_RD:      if (step == 6'd3) state_next = ST_CROSS;
      ST_CROSS:   if (step == 6'd6) state_next = ST_ABS;
      ST_ABS:     state_next = all_zero ? ST_DONE : ST_SHIFT;
      ST_SHIFT:   if (!any_big) state_next = ST_SQ;
      ST_SQ:      if (step == 6'd3) state_next = ST_SQRT;
      ST_SQRT:    if (step == 6'(SQRT_STEPS - 1)) state_next = ST_ND_GO;
      ST_ND_GO:   state_next = ST_ND_WAIT;
      ST_ND_WAIT: begin
        if (div_done) begin
          state_next = (k == 2'd2) ? ST_DONE : ST_ND_GO;
        end
      end
      ST_DONE:    if (slot_free) state_next = ST_IDLE;
      default:    state_next = ST_IDLE;
    endcase
  end

  // control outputs and operand selection
  always_comb begin
    q_pop     = 1'b0;
    div_start = 1'b0;
    div_num   = '0;
    div_den   = '0;
    ram_we    = 1'b0;
    ram_raddr = itm.cur;
    load_out  = 1'b0;
    mul_a     = '0;
    mul_b     = '0;
    unique case (state)
      ST_IDLE: q_pop = !q_empty;
      ST_BP_MUL: begin
        mul_a = 32'(axis ? itm.dy_mag : itm.dx_mag);
        mul_b = 32'(itm.z);
      end
      ST_BP_DIV: begin
        div_start = 1'b1;
        div_num   = DIV_NUM_W'({1'b0, prod[31:0], 1'b0}) + DIV_NUM_W'(ff);
        div_den   = DIV_DEN_W'({ff, 1'b0});
      end
      ST_RD: begin
        if (step == 6'd1) begin
          ram_raddr = itm.left;
        end else if (step == 6'd2) begin
          ram_raddr = itm.right;
        end
      end
      ST_CROSS: begin
        unique case (step)
          6'd0:    begin mul_a = 32'(ay); mul_b = 32'(bz); end
          6'd1:    begin mul_a = 32'(az); mul_b = 32'(by); end
          6'd2:    begin mul_a = 32'(az); mul_b = 32'(bx); end
          6'd3:    begin mul_a = 32'(ax); mul_b = 32'(bz); end
          6'd4:    begin mul_a = 32'(ax); mul_b = 32'(by); end
          6'd5:    begin mul_a = 32'(ay); mul_b = 32'(bx); end
          default: begin mul_a = '0; mul_b = '0; end
        endcase
      end
      ST_SQ: begin
        if (step < 6'd3) begin
          mul_a = $signed(mag[step[1:0]][31:0]);
          mul_b = $signed(mag[step[1:0]][31:0]);
        end
      end
      ST_ND_GO: begin
        div_start = 1'b1;
        div_num   = DIV_NUM_W'({mag[k][30:0], 15'b0}) + DIV_NUM_W'(len);
        div_den   = DIV_DEN_W'({len, 1'b0});
      end
      ST_DONE: begin
        load_out = slot_free;
        ram_we   = slot_free;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    step <= (state_next != state) ? '0 : step + 1'b1;
    prod <= mul_p;
    unique case (state)
      ST_IDLE: begin
        if (!q_empty) begin
          itm  <= q_item;
          axis <= 1'b0;
          for (int i = 0; i < 3; i++) nrm[i] <= '0;
        end
      end
      ST_BP_WAIT: begin
        if (div_done) begin
          if (axis) begin
            vy <= bp_val;
          end else begin
            vx <= bp_val;
          end
          axis <= 1'b1;
        end
      end
      ST_RD: begin
        // read data arrives in the cycle after its address
        if (step == 6'd1) begin
          ax <= (VERT_W + 1)'(vx) - (VERT_W + 1)'(rd_x);
          ay <= (VERT_W + 1)'(vy) - (VERT_W + 1)'(rd_y);
          az <= $signed({1'b0, itm.z}) - $signed({1'b0, rd_z});
        end else if (step == 6'd2) begin
          bx <= (VERT_W + 1)'(rd_x);
          by <= (VERT_W + 1)'(rd_y);
          bz <= $signed({1'b0, rd_z});
        end else if (step == 6'd3) begin
          bx <= bx - (VERT_W + 1)'(rd_x);
          by <= by - (VERT_W + 1)'(rd_y);
          bz <= bz - $signed({1'b0, rd_z});
        end
      end
      ST_CROSS: begin
        unique case (step)
          6'd0:    for (int i = 0; i < 3; i++) n[i] <= '0;
          6'd1:    n[0] <= n[0] + NACC_W'(prod);
          6'd2:    n[0] <= n[0] - NACC_W'(prod);
          6'd3:    n[1] <= n[1] + NACC_W'(prod);
          6'd4:    n[1] <= n[1] - NACC_W'(prod);
          6'd5:    n[2] <= n[2] + NACC_W'(prod);
          6'd6:    n[2] <= n[2] - NACC_W'(prod);
          default: ;
        endcase
      end
      ST_ABS: begin
        for (int i = 0; i < 3; i++) begin
          nneg[i] <= n[i][NACC_W-1];
          mag[i]  <= n[i][NACC_W-1] ? MAG_W'(-n[i]) : MAG_W'(n[i]);
        end
      end
      ST_SHIFT: begin
        sum <= '0;
        if (any_big) begin
          for (int i = 0; i < 3; i++) mag[i] <= mag[i] >> 1;
        end
      end
      ST_SQ: begin
        if (step != 6'd0) begin
          sum <= sum + 64'(prod);
        end
        if (step == 6'd3) begin
          sq_v   <= sum + 64'(prod);
          sq_r   <= '0;
          sq_bit <= 64'd1 << 62;
        end
      end
      ST_SQRT: begin
        if (sq_v >= sq_try) begin
          sq_v <= sq_v - sq_try;
          sq_r <= (sq_r >> 1) + sq_bit;
        end else begin
          sq_r <= sq_r >> 1;
        end
        sq_bit <= sq_bit >> 2;
        k      <= '0;
      end
      ST_ND_WAIT: begin
        if (div_done) begin
          nrm[k] <= nd_val;
          k      <= k + 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      vert_x       <= vx;
      vert_y       <= vy;
      vert_z       <= itm.z;
      normal_valid <= itm.nvalid;
      norm_x       <= nrm[0];
      norm_y       <= nrm[1];
      norm_z       <= nrm[2];
    end
  end

  a_div_idle: assert property (@(posedge clk) disable iff (rst)
    div_start |-> !div_busy)
    else $error("divider started while busy");

  a_sq_range: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SQ) |-> !any_big)
    else $error("component too wide for squaring");

  a_unit_q: assert property (@(posedge clk) disable iff (rst)
    (state == ST_ND_WAIT && div_done) |-> (div_quo <= UNIT_Q))
    else $error("normal component above unit length");

  a_done_pair: assert property (@(posedge clk) disable iff (rst)
    div_done |-> (state == ST_BP_WAIT || state == ST_ND_WAIT))
    else $error("divider result with no consumer");

endmodule

[sv/depth_to_vertex_normal_map.sv]
// Depth pixels enter in raster order, one per beat, and each gives one result beat: the
// pixel's camera-space vertex and the unit normal of the pixel one row above. Every
// division runs on one bit-serial divider (48 shift steps); a pixel without an interior
// normal needs two divisions, an interior pixel five divisions, a 32-step square root and
// up to 18 normalizing shifts, and the result register may also wait on out_ready. A
// two-entry queue lets new pixels be taken while one is in work and a result waits. The
// line stores are not cleared after reset and need no clearing pass.

module depth_to_vertex_normal_map (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [4:0]                         paddr,
  input  logic [31:0]                        pwdata,
  output logic [31:0]                        prdata,
  output logic                               pready,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [d2vn_pkg::DEPTH_W-1:0]       depth_mm,
  input  logic                               frame_start,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic signed [d2vn_pkg::VERT_W-1:0] vert_x,
  output logic signed [d2vn_pkg::VERT_W-1:0] vert_y,
  output logic [d2vn_pkg::DEPTH_W-1:0]       vert_z,
  output logic                               normal_valid,
  output logic signed [d2vn_pkg::NORM_W-1:0] norm_x,
  output logic signed [d2vn_pkg::NORM_W-1:0] norm_y,
  output logic signed [d2vn_pkg::NORM_W-1:0] norm_z
);
  import d2vn_pkg::*;

  cfg_t     cfg;
  reg_idx_t idx;
  logic     cfg_wr;
  logic     q_full;
  logic     q_empty;
  logic     q_push;
  logic     q_pop;
  item_t    push_item;
  item_t    pop_item;

  assign pready = 1'b1;
  assign idx    = reg_idx_t'(paddr[4:2]);
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.row_pixels   <= WID_W'(640);
      cfg.frame_rows   <= ROW_W'(480);
      cfg.depth_limit  <= 16'd65535;
      cfg.focal_len_x  <= 16'd9360;
      cfg.focal_len_y  <= 16'd9360;
      cfg.center_x     <= 16'd5120;
      cfg.center_y     <= 16'd3840;
    end else if (cfg_wr) begin
      unique case (idx)
        REG_WIDTH:  cfg.row_pixels   <= pwdata[WID_W-1:0];
        REG_HEIGHT: cfg.frame_rows   <= pwdata[ROW_W-1:0];
        REG_LIMIT:  cfg.depth_limit  <= pwdata[15:0];
        REG_FX:     cfg.focal_len_x  <= pwdata[15:0];
        REG_FY:     cfg.focal_len_y  <= pwdata[15:0];
        REG_CX:     cfg.center_x     <= pwdata[15:0];
        REG_CY:     cfg.center_y     <= pwdata[15:0];
        default:    ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_WIDTH:  prdata = 32'(cfg.row_pixels);
      REG_HEIGHT: prdata = 32'(cfg.frame_rows);
      REG_LIMIT:  prdata = 32'(cfg.depth_limit);
      REG_FX:     prdata = 32'(cfg.focal_len_x);
      REG_FY:     prdata = 32'(cfg.focal_len_y);
      REG_CX:     prdata = 32'(cfg.center_x);
      REG_CY:     prdata = 32'(cfg.center_y);
      default:    prdata = '0;
    endcase
  end

  d2vn_front u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .depth_mm   (depth_mm),
    .frame_start(frame_start),
    .q_full     (q_full),
    .q_push     (q_push),
    .q_item     (push_item)
  );

  d2vn_fifo u_fifo (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .push_item(push_item),
    .pop      (q_pop),
    .pop_item (pop_item),
    .full     (q_full),
    .empty    (q_empty)
  );

  d2vn_back u_back (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .q_empty     (q_empty),
    .q_item      (pop_item),
    .q_pop       (q_pop),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .vert_x      (vert_x),
    .vert_y      (vert_y),
    .vert_z      (vert_z),
    .normal_valid(normal_valid),
    .norm_x      (norm_x),
    .norm_y      (norm_y),
    .norm_z      (norm_z)
  );

endmodule

[bench/d2vn_checker.sv]
// result checker for depth_to_vertex_normal_map: watches the pixel and result channels,
// predicts vertex and normal per accepted pixel and compares. depends on d2vn_pkg
`timescale 1ns / 1ps

module d2vn_checker (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [4:0]                          paddr,
  input  logic [31:0]                         pwdata,
  input  logic                                pready,
  input  logic                                in_valid,
  input  logic                                in_ready,
  input  logic [d2vn_pkg::DEPTH_W-1:0]        depth_mm,
  input  logic                                frame_start,
  input  logic                                out_valid,
  input  logic                                out_ready,
  input  logic signed [d2vn_pkg::VERT_W-1:0]  vert_x,
  input  logic signed [d2vn_pkg::VERT_W-1:0]  vert_y,
  input  logic [d2vn_pkg::DEPTH_W-1:0]        vert_z,
  input  logic                                normal_valid,
  input  logic signed [d2vn_pkg::NORM_W-1:0]  norm_x,
  input  logic signed [d2vn_pkg::NORM_W-1:0]  norm_y,
  input  logic signed [d2vn_pkg::NORM_W-1:0]  norm_z,
  output int                                  fail_count,
  output int                                  pending,
  output int                                  result_count,
  output int                                  normal_count
);
  import d2vn_pkg::*;

  typedef struct packed {
    logic signed [VERT_W-1:0] vx;
    logic signed [VERT_W-1:0] vy;
    logic [DEPTH_W-1:0]       vz;
    logic                     nv;
    logic signed [NORM_W-1:0] nx;
    logic signed [NORM_W-1:0] ny;
    logic signed [NORM_W-1:0] nz;
  } result_t;

  cfg_t cfg;
  logic signed [31:0] row_x [STORE_DEPTH];
  logic signed [31:0] row_y [STORE_DEPTH];
  logic [31:0]        row_z [STORE_DEPTH];
  int unsigned col_cnt, row_cnt;
  result_t expected_q [$];

  function automatic longint project(int unsigned pos, int unsigned cen, int unsigned z,
                                     int unsigned f);
    longint d;
    longint unsigned m, ff, q;
    d  = longint'(pos) * 16 - longint'(cen);
    m  = (d < 0) ? longint'(-d) : longint'(d);
    ff = (f == 0) ? 1 : f;
    m  = m * z;
    q  = (2 * m + ff) / (2 * ff);
    if (d < 0) begin
      if (q > 8388608) q = 8388608;
      return -longint'(q);
    end
    if (q > 8388607) q = 8388607;
    return longint'(q);
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  // unit length scaling of the cross product, q1.14
  task automatic unit_scale(input longint n [3], output logic signed [NORM_W-1:0] o [3]);
    longint unsigned mag [3];
    longint unsigned sum, len, q;
    int s;
    sum = 0;
    s = 0;
    for (int k = 0; k < 3; k++) mag[k] = n[k] < 0 ? longint'(-n[k]) : longint'(n[k]);
    if (mag[0] == 0 && mag[1] == 0 && mag[2] == 0) begin
      for (int k = 0; k < 3; k++) o[k] = '0;
      return;
    end
    while ((mag[0] >> s) >= 64'h8000_0000 || (mag[1] >> s) >= 64'h8000_0000 ||
           (mag[2] >> s) >= 64'h8000_0000) s++;
    for (int k = 0; k < 3; k++) begin
      mag[k] >>= s;
      sum += mag[k] * mag[k];
    end
    len = int_sqrt(sum);
    for (int k = 0; k < 3; k++) begin
      q = (mag[k] * 32768 + len) / (2 * len);
      o[k] = n[k] < 0 ? -NORM_W'(q) : NORM_W'(q);
    end
  endtask

  task automatic predict_pixel(input logic [DEPTH_W-1:0] depth, input logic fs);
    int unsigned w, h, z, c, r, cur, above, pl, pr;
    longint vx, vy;
    longint a [3];
    longint b [3];
    longint n [3];
    logic signed [NORM_W-1:0] o [3];
    result_t res;
    w = cfg.row_pixels;
    h = cfg.frame_rows;
    z = depth;
    if (w < 3) w = 3;
    if (w > MAX_WIDTH) w = MAX_WIDTH;
    if (h < 3) h = 3;
    if (fs) begin
      col_cnt = 0;
      row_cnt = 0;
    end
    if (col_cnt >= w) begin
      col_cnt = 0;
      row_cnt++;
    end
    if (row_cnt >= h) row_cnt = 0;
    c = col_cnt;
    r = row_cnt;
    if (z > cfg.depth_limit) z = 0;
    vx = project(c, cfg.center_x, z, cfg.focal_len_x);
    vy = project(r, cfg.center_y, z, cfg.focal_len_y);
    cur = ((r & 1) * MAX_WIDTH + c) % STORE_DEPTH;
    above = ((r + 1) & 1) * MAX_WIDTH;
    res = '0;
    if (r != 0) begin
      res.nv = 1'b1;
      if (r - 1 != 0 && c != 0 && c != w - 1) begin
        pl = (above + c - 1) % STORE_DEPTH;
        pr = (above + c + 1) % STORE_DEPTH;
        a[0] = vx - row_x[cur];
        a[1] = vy - row_y[cur];
        a[2] = longint'(z) - longint'(row_z[cur]);
        b[0] = longint'(row_x[pl]) - row_x[pr];
        b[1] = longint'(row_y[pl]) - row_y[pr];
        b[2] = longint'(row_z[pl]) - longint'(row_z[pr]);
        n[0] = a[1] * b[2] - a[2] * b[1];
        n[1] = a[2] * b[0] - a[0] * b[2];
        n[2] = a[0] * b[1] - a[1] * b[0];
        unit_scale(n, o);
        res.nx = o[0];
        res.ny = o[1];
        res.nz = o[2];
      end
    end
    row_x[cur] = vx;
    row_y[cur] = vy;
    row_z[cur] = z;
    col_cnt = c + 1;
    if (col_cnt >= w) begin
      col_cnt = 0;
      row_cnt = r + 1;
      if (row_cnt >= h) row_cnt = 0;
    end
    res.vx = VERT_W'(vx);
    res.vy = VERT_W'(vy);
    res.vz = DEPTH_W'(z);
    expected_q.push_back(res);
  endtask

  always @(posedge clk) begin
    result_t got, exp_r;
    if (rst) begin
      cfg <= '{row_pixels: 640, frame_rows: 480, depth_limit: 16'hFFFF,
               focal_len_x: 9360, focal_len_y: 9360, center_x: 5120, center_y: 3840};
      col_cnt = 0;
      row_cnt = 0;
      for (int k = 0; k < STORE_DEPTH; k++) begin
        row_x[k] = 0;
        row_y[k] = 0;
        row_z[k] = 0;
      end
      fail_count <= 0;
      pending <= 0;
      result_count <= 0;
      normal_count <= 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (reg_idx_t'(paddr[4:2]))
          REG_WIDTH:  cfg.row_pixels   <= pwdata[WID_W-1:0];
          REG_HEIGHT: cfg.frame_rows   <= pwdata[ROW_W-1:0];
          REG_LIMIT:  cfg.depth_limit  <= pwdata[15:0];
          REG_FX:     cfg.focal_len_x  <= pwdata[15:0];
          REG_FY:     cfg.focal_len_y  <= pwdata[15:0];
          REG_CX:     cfg.center_x     <= pwdata[15:0];
          REG_CY:     cfg.center_y     <= pwdata[15:0];
          default: ;
        endcase
      end
      if (in_valid && in_ready) predict_pixel(depth_mm, frame_start);
      if (out_valid && out_ready) begin
        got = '{vert_x, vert_y, vert_z, normal_valid, norm_x, norm_y, norm_z};
        result_count <= result_count + 1;
        if (expected_q.size() == 0) begin
          $display("%0t: unexpected result beat %p", $time, got);
          fail_count <= fail_count + 1;
        end else begin
          exp_r = expected_q.pop_front();
          if (exp_r.nx != 0 || exp_r.ny != 0 || exp_r.nz != 0) normal_count <= normal_count + 1;
          if (got !== exp_r) begin
            $display("%0t: mismatch expected %p actual %p", $time, exp_r, got);
            fail_count <= fail_count + 1;
          end
        end
      end
      pending <= expected_q.size();
    end
  end

endmodule

[bench/tb_depth_to_vertex_normal_map.sv]
// stimulus and verdict for depth_to_vertex_normal_map: apb setup, pixel frames, stalls
// depends on d2vn_pkg, the block and d2vn_checker
`timescale 1ns / 1ps

module tb_depth_to_vertex_normal_map;
  import d2vn_pkg::*;

  logic clk, rst;
  logic psel, penable, pwrite, pready;
  logic [4:0] paddr;
  logic [31:0] pwdata, prdata;
  logic in_valid, in_ready, frame_start, out_valid, out_ready, normal_valid;
  logic [DEPTH_W-1:0] depth_mm, vert_z;
  logic signed [VERT_W-1:0] vert_x, vert_y;
  logic signed [NORM_W-1:0] norm_x, norm_y, norm_z;
  int fail_count, pending, result_count, normal_count;
  int pixel_count;
  bit hold_off;

  depth_to_vertex_normal_map i_dut (.*);

  d2vn_checker i_check (.*);

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  initial begin
    #400ms;
    $display("CHECK FAILED");
    $finish;
  end

  // drops valid only when a gap follows, so back to back beats keep it high
  task automatic idle_gap();
    int n;
    n = ($urandom_range(0, 19) == 0) ? $urandom_range(5, 40) : $urandom_range(0, 2);
    if ($urandom_range(0, 2) == 0) n = 0;
    if (n != 0) in_valid <= 0;
    repeat (n) @(negedge clk);
  endtask

  task automatic reg_write(reg_idx_t idx, int unsigned val);
    psel <= 1;
    penable <= 0;
    pwrite <= 1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(negedge clk);
    penable <= 1;
    @(negedge clk);
    psel <= 0;
    penable <= 0;
    pwrite <= 0;
    @(negedge clk);
  endtask

  task automatic send_pixel(logic [DEPTH_W-1:0] d, logic fs);
    in_valid <= 1;
    depth_mm <= d;
    frame_start <= fs;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pixel_count++;
    @(negedge clk);
  endtask

  // waits for every result, then for the back end to go quiet
  task automatic drain();
    int n;
    n = 0;
    in_valid <= 0;
    while (pending != 0 && n < 2000000) begin
      @(negedge clk);
      n++;
    end
    repeat (400) @(negedge clk);
  endtask

  // a frame of smooth depth with random ripple, noise and cut-off samples
  task automatic send_frame(int w, int h, int mode);
    int base;
    logic [DEPTH_W-1:0] d;
    base = $urandom_range(300, 60000);
    for (int r = 0; r < h; r++) begin
      for (int c = 0; c < w; c++) begin
        case (mode)
          0: d = 16'(base + r * $urandom_range(0, 40) + c * $urandom_range(0, 40));
          1: d = 16'($urandom);
          default: d = ($urandom_range(0, 5) == 0) ? 16'd0 : 16'(base + $urandom_range(0, 200));
        endcase
        send_pixel(d, r == 0 && c == 0);
        idle_gap();
      end
    end
  endtask

  task automatic set_all(int w, int h, int lim, int fx, int fy, int cx, int cy);
    reg_write(REG_WIDTH, w);
    reg_write(REG_HEIGHT, h);
    reg_write(REG_LIMIT, lim);
    reg_write(REG_FX, fx);
    reg_write(REG_FY, fy);
    reg_write(REG_CX, cx);
    reg_write(REG_CY, cy);
  endtask

  // receiver stalls, with one long hold-off counted on its own
  initial begin
    out_ready = 0;
    forever begin
      @(negedge clk);
      if (hold_off) begin
        out_ready <= 0;
        repeat (3000) @(negedge clk);
        hold_off = 0;
      end
      if ($urandom_range(0, 60) == 0) begin
        out_ready <= 0;
        repeat ($urandom_range(10, 500)) @(negedge clk);
      end else begin
        out_ready <= ($urandom_range(0, 3) != 0);
      end
    end
  end

  initial begin
    int w, h;
    rst = 1;
    psel = 0;
    penable = 0;
    pwrite = 0;
    paddr = '0;
    pwdata = '0;
    in_valid = 0;
    depth_mm = '0;
    frame_start = 0;
    pixel_count = 0;
    hold_off = 0;
    repeat (9) @(negedge clk);
    rst = 0;
    @(negedge clk);
    // directed: extremes of every field on a 3 by 3 frame and a wrap into a second frame
    set_all(3, 3, 65535, 16, 65535, 0, 65535);
    send_pixel(16'hFFFF, 1);
    send_pixel(16'd0, 0);
    send_pixel(16'd1, 0);
    send_pixel(16'd1000, 0);
    send_pixel(16'd1000, 0);
    send_pixel(16'd1000, 0);
    send_pixel(16'hFFFF, 0);
    send_pixel(16'h8000, 0);
    send_pixel(16'h7FFF, 0);
    send_pixel(16'd500, 0);
    send_pixel(16'd500, 0);
    drain();
    // sizes below the minimum, zero focal lengths, zero limit
    set_all(0, 0, 0, 0, 0, 65535, 0);
    for (int k = 0; k < 10; k++) send_pixel(16'(k * 7000), k == 0);
    drain();
    set_all(2047, 4095, 40000, 9360, 9360, 5120, 3840);
    for (int k = 0; k < 12; k++) send_pixel(16'(1000 + k), k == 0);
    drain();
    // long receiver hold-off while pixels keep coming
    hold_off = 1;
    set_all(5, 4, 65535, 2000, 3000, 40, 30);
    send_frame(5, 4, 0);
    drain();
    while (pixel_count < 1240) begin
      w = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 40) : $urandom_range(3, 8);
      h = $urandom_range(3, 6);
      set_all(w, h, ($urandom_range(0, 3) == 0) ? $urandom : 65535,
              $urandom_range(16, 65535), $urandom_range(16, 65535),
              $urandom_range(0, 65535), $urandom_range(0, 65535));
      send_frame(w, h, $urandom_range(0, 2));
      drain();
    end
    $display("covered %0d pixels and %0d results, %0d with a nonzero normal",
             pixel_count, result_count, normal_count);
    if (fail_count == 0 && pending == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

[filelist.f]
sv/d2vn_pkg.sv
sv/d2vn_ram.sv
sv/d2vn_div.sv
sv/d2vn_fifo.sv
sv/d2vn_front.sv
sv/d2vn_back.sv
sv/depth_to_vertex_normal_map.sv
bench/d2vn_checker.sv
bench/tb_depth_to_vertex_normal_map.sv
